/* rtl/mfp_pkg.sv */
// Shared types, codes and defaults for the five-stage MIPS-subset pipeline.
// No dependencies; imported by mfp_ex, mfp_core and the top level.
package mfp_pkg;

  localparam int DEF_IMEM_WORDS = 1024;
  localparam int DEF_DMEM_WORDS = 1024;

  // Stream command carried in tuser
  typedef enum logic [2:0] {
    CMD_LOAD_INSTR = 3'd0,
    CMD_LOAD_DATA  = 3'd1,
    CMD_LOAD_REG   = 3'd2,
    CMD_TICK       = 3'd3,
    CMD_READ_REG   = 3'd4,
    CMD_READ_DATA  = 3'd5
  } cmd_t;

  // Primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;

  // R-type function codes
  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR  = 6'h25;
  localparam logic [5:0] FN_XOR = 6'h26;
  localparam logic [5:0] FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2A;

  // EX/MEM control
  typedef struct packed {
    logic       mem_to_reg;
    logic       reg_write;
    logic       mem_write;
    logic       mem_read;
    logic [4:0] dest;
  } ex_ctrl_t;

  // MEM/WB control
  typedef struct packed {
    logic       mem_to_reg;
    logic       reg_write;
    logic [4:0] dest;
  } mem_ctrl_t;

  // What the execute stage hands back to the pipeline
  typedef struct packed {
    ex_ctrl_t    ctrl;
    logic        result_we;
    logic [31:0] result;
    logic        store_we;
    logic [31:0] store_data;
    logic        redirect;
    logic [31:0] target;
  } ex_out_t;

  // Write-back of one tick
  typedef struct packed {
    logic        write;
    logic [4:0]  rnum;
    logic [31:0] value;
  } wb_info_t;

endpackage

/* rtl/mfp_ram.sv */
// Generic single-write, single-read RAM with registered, enabled read port.
// No dependencies.
module mfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mfp_ex.sv */
// Execute stage: decode of the ID/EX word, ALU, branch and jump resolution.
// Depends on mfp_pkg.
module mfp_ex (
  input  logic [31:0]       decode_word,
  input  logic [31:0]       decode_addr,
  input  logic [31:0]       op_a,
  input  logic [31:0]       op_b,
  input  logic [4:0]        prev_dest,
  output mfp_pkg::ex_out_t  ex_out
);
  import mfp_pkg::*;

  logic [5:0]  opcode;
  logic [5:0]  funct;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  shamt;
  logic [31:0] imm;
  logic [31:0] next_pc;
  logic [31:0] br_target;

  assign opcode    = decode_word[31:26];
  assign funct     = decode_word[5:0];
  assign rt        = decode_word[20:16];
  assign rd        = decode_word[15:11];
  assign shamt     = decode_word[10:6];
  assign imm       = {{16{decode_word[15]}}, decode_word[15:0]};
  assign next_pc   = decode_addr + 32'd4;
  assign br_target = next_pc + {imm[29:0], 2'b00};

  always_comb begin
    ex_out            = '0;
    ex_out.ctrl.dest  = prev_dest;   // dest field holds when nothing overrides it
    ex_out.result     = op_a + imm;
    ex_out.store_data = op_b;
    ex_out.target     = br_target;
    case (opcode)
      OP_RTYPE: begin
        ex_out.result_we = 1'b1;
        case (funct)
          FN_ADD:  ex_out.result = op_a + op_b;
          FN_SUB:  ex_out.result = op_a - op_b;
          FN_AND:  ex_out.result = op_a & op_b;
          FN_OR:   ex_out.result = op_a | op_b;
          FN_NOR:  ex_out.result = ~(op_a | op_b);
          FN_XOR:  ex_out.result = op_a ^ op_b;
          FN_SLT:  ex_out.result = {31'd0, ($signed(op_a) < $signed(op_b))};
          FN_SLL:  ex_out.result = op_b << shamt;
          default: ex_out.result_we = 1'b0;
        endcase
        if (ex_out.result_we) begin
          ex_out.ctrl.reg_write = 1'b1;
          ex_out.ctrl.dest      = rd;
        end
      end
      OP_ADDI: begin
        ex_out.result_we      = 1'b1;
        ex_out.ctrl.reg_write = 1'b1;
        ex_out.ctrl.dest      = rt;
      end
      OP_LW: begin
        ex_out.result_we       = 1'b1;
        ex_out.ctrl.mem_read   = 1'b1;
        ex_out.ctrl.reg_write  = 1'b1;
        ex_out.ctrl.mem_to_reg = 1'b1;
        ex_out.ctrl.dest       = rt;
      end
      OP_SW: begin
        ex_out.result_we      = 1'b1;
        ex_out.store_we       = 1'b1;
        ex_out.ctrl.mem_write = 1'b1;
      end
      OP_BEQ: begin
        ex_out.redirect = (op_a == op_b);
      end
      OP_BNE: begin
        ex_out.redirect = (op_a != op_b);
      end
      OP_J: begin
        ex_out.redirect = 1'b1;
        ex_out.target   = {next_pc[31:28], decode_word[25:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/mfp_core.sv */
// Pipeline state: PC, IF/ID/EX/MEM/WB registers, register file and memories.
// Depends on mfp_pkg, mfp_ram and mfp_ex.
module mfp_core #(
  parameter int IMEM_WORDS = mfp_pkg::DEF_IMEM_WORDS,
  parameter int DMEM_WORDS = mfp_pkg::DEF_DMEM_WORDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,         // item transfer this cycle
  input  mfp_pkg::cmd_t      cmd,
  input  logic [9:0]         idx,
  input  logic [31:0]        value,
  output logic [31:0]        pc_after,   // PC once this item is done
  output mfp_pkg::wb_info_t  wb,         // write-back of this tick
  output logic [31:0]        rd_reg,     // register read, valid cycle after
  output logic [31:0]        rd_data     // data word read, valid cycle after
);
  import mfp_pkg::*;

  localparam int IAW = $clog2(IMEM_WORDS);
  localparam int DAW = $clog2(DMEM_WORDS);

  logic        go_tick;
  logic [31:0] idx_ext;

  // pipeline registers
  logic [31:0] pc_r, pc_nxt;
  logic [31:0] fetch_addr_r;
  logic        fw_ok_r;
  logic [31:0] decode_word_r, decode_addr_r;
  logic [31:0] ex_result_r, ex_store_r;
  ex_ctrl_t    ex_ctrl_r;
  logic [31:0] mem_result_r;
  mem_ctrl_t   mem_ctrl_r;

  // memory side
  logic [31:0] imem_rdata, dmem_rdata, rfa_rdata, rfb_rdata;
  logic [31:0] fetch_word;
  logic [31:0] mem_ld_data;
  logic        dsel_r;
  logic [31:0] ld_hold_r;
  logic [31:0] rf_vld_r;
  logic        rfa_ok_r, rfa_byp_r, rfb_ok_r, rfb_byp_r;
  logic        asel_r;
  logic [31:0] a_hold_r;
  logic [31:0] wbv_r;
  logic [31:0] a_eff, op_a, op_b;

  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;
  logic        rfa_re;
  logic [4:0]  rfa_raddr, rfb_raddr;
  logic        dm_re, dm_we;
  logic [DAW-1:0] dm_raddr, dm_waddr;
  logic [31:0] dm_wdata;
  logic [31:0] pc_ex;
  ex_out_t     ex_out;

  assign go_tick = go && (cmd == CMD_TICK);
  assign idx_ext = {22'd0, idx};

  // operand views of the RAM read registers
  assign fetch_word  = fw_ok_r ? imem_rdata : 32'd0;
  assign mem_ld_data = dsel_r ? dmem_rdata : ld_hold_r;
  assign a_eff       = rfa_byp_r ? wbv_r : (rfa_ok_r ? rfa_rdata : 32'd0);
  assign op_a        = asel_r ? a_eff : a_hold_r;
  assign op_b        = rfb_byp_r ? wbv_r : (rfb_ok_r ? rfb_rdata : 32'd0);

  // WB
  always_comb begin
    wb.write = mem_ctrl_r.reg_write && (mem_ctrl_r.dest != 5'd0);
    wb.rnum  = mem_ctrl_r.dest;
    wb.value = mem_ctrl_r.mem_to_reg ? mem_ld_data : mem_result_r;
    if (!wb.write) begin
      wb = '0;
    end
  end

  // EX
  mfp_ex u_ex (
    .decode_word (decode_word_r),
    .decode_addr (decode_addr_r),
    .op_a        (op_a),
    .op_b        (op_b),
    .prev_dest   (ex_ctrl_r.dest),
    .ex_out      (ex_out)
  );

  assign pc_ex    = ex_out.redirect ? ex_out.target : pc_r;
  assign pc_nxt   = pc_ex + 32'd4;
  assign pc_after = go_tick ? pc_nxt : pc_r;

  // register file: two copies, one per read port
  assign rf_we     = (go_tick && wb.write) ||
                     (go && (cmd == CMD_LOAD_REG) && (idx[4:0] != 5'd0));
  assign rf_waddr  = go_tick ? wb.rnum : idx[4:0];
  assign rf_wdata  = go_tick ? wb.value : value;
  assign rfa_re    = go_tick || (go && (cmd == CMD_READ_REG));
  assign rfa_raddr = go_tick ? fetch_word[25:21] : idx[4:0];
  assign rfb_raddr = fetch_word[20:16];

  mfp_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk (clk), .we (rf_we), .waddr (rf_waddr), .wdata (rf_wdata),
    .re (rfa_re), .raddr (rfa_raddr), .rdata (rfa_rdata)
  );

  mfp_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk (clk), .we (rf_we), .waddr (rf_waddr), .wdata (rf_wdata),
    .re (go_tick), .raddr (rfb_raddr), .rdata (rfb_rdata)
  );

  // data memory: MEM stage on a tick, else load / read commands
  assign dm_re    = (go_tick && ex_ctrl_r.mem_read) || (go && (cmd == CMD_READ_DATA));
  assign dm_we    = (go_tick && ex_ctrl_r.mem_write) || (go && (cmd == CMD_LOAD_DATA));
  assign dm_raddr = go_tick ? ex_result_r[DAW+1:2] : idx_ext[DAW-1:0];
  assign dm_waddr = go_tick ? ex_result_r[DAW+1:2] : idx_ext[DAW-1:0];
  assign dm_wdata = go_tick ? ex_store_r : value;

  mfp_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
    .clk (clk), .we (dm_we), .waddr (dm_waddr), .wdata (dm_wdata),
    .re (dm_re), .raddr (dm_raddr), .rdata (dmem_rdata)
  );

  // instruction memory: IF reads at the PC left by EX
  mfp_ram #(.WIDTH(32), .DEPTH(IMEM_WORDS)) u_imem (
    .clk   (clk),
    .we    (go && (cmd == CMD_LOAD_INSTR)),
    .waddr (idx_ext[IAW-1:0]),
    .wdata (value),
    .re    (go_tick),
    .raddr (pc_ex[IAW+1:2]),
    .rdata (imem_rdata)
  );

  assign rd_reg  = a_eff;
  assign rd_data = dmem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= '0;
      fetch_addr_r  <= '0;
      fw_ok_r       <= 1'b0;
      decode_word_r <= '0;
      decode_addr_r <= '0;
      ex_result_r   <= '0;
      ex_store_r    <= '0;
      ex_ctrl_r     <= '0;
      mem_result_r  <= '0;
      mem_ctrl_r    <= '0;
      dsel_r        <= 1'b0;
      ld_hold_r     <= '0;
      rf_vld_r      <= '0;
      rfa_ok_r      <= 1'b0;
      rfa_byp_r     <= 1'b0;
      rfb_ok_r      <= 1'b0;
      rfb_byp_r     <= 1'b0;
      asel_r        <= 1'b0;
      a_hold_r      <= '0;
      wbv_r         <= '0;
    end else begin
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
      // port A: tick reads rs, read command reads idx
      if (rfa_re) begin
        rfa_ok_r  <= rf_vld_r[rfa_raddr];
        rfa_byp_r <= go_tick && wb.write && (wb.rnum == rfa_raddr);
      end
      if (go && (cmd == CMD_READ_REG)) begin
        asel_r   <= 1'b0;
        a_hold_r <= op_a;
      end
      // data read register shared by MEM loads and read commands
      if (go && (cmd == CMD_READ_DATA)) begin
        dsel_r    <= 1'b0;
        ld_hold_r <= mem_ld_data;
      end
      if (go_tick) begin
        wbv_r     <= wb.value;
        rfb_ok_r  <= rf_vld_r[rfb_raddr];
        rfb_byp_r <= wb.write && (wb.rnum == rfb_raddr);
        asel_r    <= 1'b1;
        if (ex_ctrl_r.mem_read) begin
          dsel_r <= 1'b1;
        end
        // MEM
        mem_result_r          <= ex_result_r;
        mem_ctrl_r.dest       <= ex_ctrl_r.dest;
        mem_ctrl_r.reg_write  <= ex_ctrl_r.reg_write;
        mem_ctrl_r.mem_to_reg <= ex_ctrl_r.mem_to_reg;
        // EX
        ex_ctrl_r <= ex_out.ctrl;
        if (ex_out.result_we) begin
          ex_result_r <= ex_out.result;
        end
        if (ex_out.store_we) begin
          ex_store_r <= ex_out.store_data;
        end
        // ID
        decode_word_r <= fetch_word;
        decode_addr_r <= fetch_addr_r;
        // IF
        fetch_addr_r <= pc_ex;
        fw_ok_r      <= 1'b1;
        pc_r         <= pc_nxt;
      end
    end
  end

endmodule

/* rtl/mips_five_stage_pipeline.sv */
// Top level of the five-stage MIPS-subset pipeline with stream ports.
// Depends on mfp_pkg and mfp_core (which uses mfp_ex and mfp_ram).
//
// One command arrives per input transfer (tuser): load an instruction word,
// data word or register, read back a register or data word, or advance the
// pipeline one tick. A tick runs WB, MEM, EX, ID and IF in that order;
// ID sees the register written by WB in the same tick, there is no
// forwarding and no interlock, and a taken beq/bne/j resolves in EX so one
// delay-slot instruction still runs. Every command returns exactly one
// result transfer carrying the read value (zero unless a read), the PC after
// the command and the tick's write-back. The block takes one command per
// clock whenever the output side is ready: commands update the pipeline
// state in the cycle they are transferred, and a result stage then picks up
// the registered memory or register-file read data and passes it on to the
// output register. Instruction, data and register storage are RAMs with
// registered reads; memory sizes must be powers of two and addresses wrap
// to the memory depth. Unwritten memory words read back as undefined;
// registers reset to zero.
module mips_five_stage_pipeline #(
  parameter int IMEM_WORDS = mfp_pkg::DEF_IMEM_WORDS,
  parameter int DMEM_WORDS = mfp_pkg::DEF_DMEM_WORDS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // [9:0] index, [41:10] value, [47:42] zero
  input  logic [2:0]   in_tuser,   // [2:0] cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // [31:0] read_value, [63:32] fetch_pc,
                                   // [64] wb_write, [69:65] wb_reg,
                                   // [101:70] wb_value, [103:102] zero
);
  import mfp_pkg::*;

  logic        in_xfer;
  cmd_t        in_cmd;
  logic [31:0] pc_after;
  wb_info_t    wb;
  logic [31:0] rd_reg, rd_data;

  // result stage: holds the command while the RAM read data is registered
  logic        s1_valid_r;
  cmd_t        s1_cmd_r;
  logic [31:0] s1_pc_r;
  wb_info_t    s1_wb_r;
  logic        s1_adv;
  logic [31:0] read_value;

  logic         out_valid_r;
  logic [103:0] out_data_r;

  assign in_cmd    = cmd_t'(in_tuser);
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  mfp_core #(
    .IMEM_WORDS (IMEM_WORDS),
    .DMEM_WORDS (DMEM_WORDS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (in_xfer),
    .cmd      (in_cmd),
    .idx      (in_tdata[9:0]),
    .value    (in_tdata[41:10]),
    .pc_after (pc_after),
    .wb       (wb),
    .rd_reg   (rd_reg),
    .rd_data  (rd_data)
  );

  always_comb begin
    case (s1_cmd_r)
      CMD_READ_REG:  read_value = rd_reg;
      CMD_READ_DATA: read_value = rd_data;
      default:       read_value = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r <= in_cmd;
      s1_pc_r  <= pc_after;
      s1_wb_r  <= (in_cmd == CMD_TICK) ? wb : '0;
    end
    if (s1_adv) begin
      out_data_r <= {2'b00, s1_wb_r.value, s1_wb_r.rnum, s1_wb_r.write,
                     s1_pc_r, read_value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // no transfer may land on a result stage that cannot drain
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> (!s1_valid_r || s1_adv))
    else $error("input transfer overran result stage");

  // a waiting result stays put until the output register frees up
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_pc_r)))
    else $error("result stage lost a pending result");

  // only ticks report a write-back
  a_wb_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_cmd != CMD_TICK)) |=> !s1_wb_r.write)
    else $error("write-back reported for a non-tick command");

endmodule
